// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL; every check uses clk and arst_n of the includer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/ps2hce_pkg.sv =====
package ps2hce_pkg;

	localparam int TIMER_BITS_DEF = 24;
	localparam int TMO_W = 24;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TMO = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AUX = 8'd3;

	localparam logic [TMO_W-1:0] WAIT_TMO_RST = 24'd40000;
	localparam logic [TMO_W-1:0] IDLE_TMO_RST = 24'd1000000;
	localparam logic [3:0] RETRY_RST = 4'd5;

	localparam logic [1:0] KIND_SEND = 2'd0;
	localparam logic [1:0] KIND_KEY = 2'd1;
	localparam logic [1:0] KIND_PKT = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [2:0] ST_KB_READY = 3'd0;
	localparam logic [2:0] ST_MOUSE_READY = 3'd1;
	localparam logic [2:0] ST_WHEEL_READY = 3'd2;
	localparam logic [2:0] ST_RESET_SEEN = 3'd3;
	localparam logic [2:0] ST_LOST = 3'd4;
	localparam logic [2:0] ST_GAVE_UP = 3'd5;

	localparam logic [1:0] PFX_NONE = 2'd0;
	localparam logic [1:0] PFX_E0 = 2'd1;
	localparam logic [1:0] PFX_F0 = 2'd2;
	localparam logic [1:0] PFX_E0F0 = 2'd3;

	localparam logic [7:0] B_ACK = 8'hFA;
	localparam logic [7:0] B_RESEND = 8'hFE;
	localparam logic [7:0] B_SELFTEST = 8'hAA;
	localparam logic [7:0] B_RESET = 8'hFF;
	localparam logic [7:0] B_ECHO = 8'hEE;
	localparam logic [7:0] B_READ_DATA = 8'hEB;
	localparam logic [7:0] B_KB_ID1 = 8'hAB;
	localparam logic [7:0] B_KB_ID2 = 8'h83;
	localparam logic [7:0] B_WHEEL_ID = 8'h03;
	localparam logic [7:0] B_EXT = 8'hE0;
	localparam logic [7:0] B_BREAK = 8'hF0;

	localparam logic [4:0] CMD_FIRST = 5'd0;
	localparam logic [4:0] CMD_ID = 5'd1;
	localparam logic [4:0] CMD_MOUSE = 5'd2;
	localparam logic [4:0] CMD_M_ID = 5'd8;
	localparam logic [4:0] CMD_M_TAIL = 5'd9;
	localparam logic [4:0] CMD_M_LAST = 5'd11;
	localparam logic [4:0] CMD_KB = 5'd12;
	localparam logic [4:0] CMD_KB_LAST = 5'd16;

	typedef enum logic [7:0] {
		PH_CMD    = 8'b0000_0001,
		PH_WAIT_AA = 8'b0000_0010,
		PH_DROP   = 8'b0000_0100,
		PH_ID1    = 8'b0000_1000,
		PH_KB_ID2 = 8'b0001_0000,
		PH_M_ID2  = 8'b0010_0000,
		PH_KEYBD  = 8'b0100_0000,
		PH_MOUSE  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [4:0] cmd_idx;
		logic [3:0] setup_fails;
		logic [1:0] pfx;
		logic probe;
		logic [1:0] pos;
		logic wheel;
	} ctl_t;

	typedef struct packed {
		logic [TMO_W-1:0] wait_tmo;
		logic [TMO_W-1:0] idle_tmo;
		logic [3:0] retry;
		logic aux;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] code;
		logic key_release;
		logic [7:0] pkt_byte0;
		logic [7:0] pkt_byte1;
		logic [7:0] pkt_byte2;
		logic [7:0] pkt_byte3;
		logic [2:0] pkt_len;
		logic [2:0] status;
		logic aux_prefix;
	} res_t;

	function automatic logic [7:0] cmd_byte(input logic [4:0] idx);
		logic [7:0] b;
		unique case (idx)
			5'd0: b = 8'hF5;
			5'd1: b = 8'hF2;
			5'd2: b = 8'hF3;
			5'd3: b = 8'd200;
			5'd4: b = 8'hF3;
			5'd5: b = 8'd100;
			5'd6: b = 8'hF3;
			5'd7: b = 8'd80;
			5'd8: b = 8'hF2;
			5'd9: b = 8'hF3;
			5'd10: b = 8'd40;
			5'd11: b = 8'hF4;
			5'd12: b = 8'hF0;
			5'd13: b = 8'h02;
			5'd14: b = 8'hF3;
			5'd15: b = 8'h7F;
			5'd16: b = 8'hF4;
			default: b = 8'hF5;
		endcase
		return b;
	endfunction

endpackage

// ===== design/ps2hce_step.sv =====
module ps2hce_step #(
	parameter int TIMER_BITS = ps2hce_pkg::TIMER_BITS_DEF
) (
	input  ps2hce_pkg::cfg_t cfg,
	input  ps2hce_pkg::ctl_t cur,
	input  logic [TIMER_BITS-1:0] timer,
	input  logic [2:0][7:0] store,
	input  logic func,
	input  logic [7:0] data_byte,
	output ps2hce_pkg::ctl_t nxt,
	output logic [TIMER_BITS-1:0] timer_nxt,
	output logic store_we,
	output logic [1:0] store_idx,
	output logic res_v,
	output ps2hce_pkg::res_t res
);
	import ps2hce_pkg::*;

	localparam int CW = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;

	logic [TIMER_BITS-1:0] timer_inc;
	logic [3:0] fail_inc;
	logic [TMO_W-1:0] thr;
	logic idle;
	logic fire;
	logic go_cmd;
	logic [4:0] go_idx;
	logic go_fail;
	logic go_lost;
	logic go_ready;
	phase_t ready_ph;
	logic [2:0] ready_st;
	logic go_kb_err;
	logic [2:0] len;
	logic [1:0] st;

	assign timer_inc = (&timer) ? timer : timer + 1'b1;
	assign fail_inc = (&cur.setup_fails) ? cur.setup_fails : cur.setup_fails + 4'd1;
	assign idle = (cur.phase == PH_KEYBD) || (cur.phase == PH_MOUSE);
	assign thr = idle ? cfg.idle_tmo : cfg.wait_tmo;
	assign fire = CW'(timer_inc) >= CW'(thr);
	assign len = cur.wheel ? 3'd4 : 3'd3;
	assign st = cur.pfx;
	assign store_idx = cur.pos;

	always_comb begin
		nxt = cur;
		timer_nxt = timer;
		store_we = 1'b0;
		res_v = 1'b0;
		res = '0;
		go_cmd = 1'b0;
		go_idx = CMD_FIRST;
		go_fail = 1'b0;
		go_lost = 1'b0;
		go_ready = 1'b0;
		ready_ph = PH_KEYBD;
		ready_st = ST_KB_READY;
		go_kb_err = 1'b0;

		if (!func) begin
			timer_nxt = '0;
			unique case (cur.phase)
				PH_CMD: begin
					if (data_byte == B_RESEND) begin
						go_cmd = 1'b1;
						go_idx = cur.cmd_idx;
					end else if (data_byte != B_ACK) begin
						go_fail = 1'b1;
					end else begin
						priority case (cur.cmd_idx)
							CMD_ID: nxt.phase = PH_ID1;
							CMD_M_ID: nxt.phase = PH_M_ID2;
							CMD_M_LAST: begin
								go_ready = 1'b1;
								ready_ph = PH_MOUSE;
								ready_st = cur.wheel ? ST_WHEEL_READY : ST_MOUSE_READY;
							end
							CMD_KB_LAST: begin
								go_ready = 1'b1;
								ready_ph = PH_KEYBD;
								ready_st = ST_KB_READY;
							end
							default: begin
								go_cmd = 1'b1;
								go_idx = cur.cmd_idx + 5'd1;
							end
						endcase
					end
				end
				PH_WAIT_AA: begin
					if (data_byte == B_SELFTEST) begin
						nxt.phase = PH_DROP;
						res_v = 1'b1;
						res.kind = KIND_STATUS;
						res.status = ST_RESET_SEEN;
					end
				end
				PH_DROP: begin
					go_cmd = 1'b1;
					go_idx = CMD_FIRST;
				end
				PH_ID1: begin
					if (data_byte == 8'h00) begin
						go_cmd = 1'b1;
						go_idx = CMD_MOUSE;
					end else if (data_byte == B_KB_ID1) begin
						nxt.phase = PH_KB_ID2;
					end else begin
						go_fail = 1'b1;
					end
				end
				PH_KB_ID2: begin
					if (data_byte == B_KB_ID2) begin
						go_cmd = 1'b1;
						go_idx = CMD_KB;
					end else begin
						go_fail = 1'b1;
					end
				end
				PH_M_ID2: begin
					if (data_byte == 8'h00 || data_byte == B_WHEEL_ID) begin
						nxt.wheel = (data_byte == B_WHEEL_ID);
						go_cmd = 1'b1;
						go_idx = CMD_M_TAIL;
					end else begin
						go_fail = 1'b1;
					end
				end
				PH_KEYBD: begin
					nxt.probe = 1'b0;
					if (data_byte == 8'h00 || data_byte == B_SELFTEST ||
					    data_byte == 8'hFC || data_byte == 8'hFD ||
					    data_byte == B_RESEND || data_byte == B_RESET) begin
						go_kb_err = 1'b1;
					end else if (data_byte == B_ECHO || data_byte == B_ACK) begin
						nxt.pfx = cur.pfx;
					end else if (st == PFX_NONE &&
					             (data_byte == B_EXT || data_byte == B_BREAK)) begin
						nxt.pfx = (data_byte == B_EXT) ? PFX_E0 : PFX_F0;
					end else if (st == PFX_E0 && data_byte == B_BREAK) begin
						nxt.pfx = PFX_E0F0;
					end else begin
						res_v = 1'b1;
						res.kind = KIND_KEY;
						res.code = data_byte;
						if ((st == PFX_E0 || st == PFX_E0F0) && !data_byte[7]) begin
							res.code[7] = 1'b1;
						end
						res.key_release = (st == PFX_F0 || st == PFX_E0F0);
						nxt.pfx = PFX_NONE;
					end
				end
				PH_MOUSE: begin
					if (cur.probe && data_byte == B_ACK) begin
						nxt.probe = 1'b0;
					end else if (cur.pos == 2'd0 && !data_byte[3]) begin
						nxt.pos = cur.pos;
					end else if (({1'b0, cur.pos} + 3'd1) < len && cur.pos != 2'd3) begin
						store_we = 1'b1;
						nxt.pos = cur.pos + 2'd1;
					end else begin
						res_v = 1'b1;
						res.kind = KIND_PKT;
						res.pkt_byte0 = store[0];
						res.pkt_byte1 = store[1];
						if (cur.wheel) begin
							res.pkt_byte2 = store[2];
							res.pkt_byte3 = data_byte;
						end else begin
							res.pkt_byte2 = data_byte;
						end
						res.pkt_len = len;
						nxt.pos = 2'd0;
					end
				end
				default: begin
					go_kb_err = 1'b0;
					nxt.phase = PH_WAIT_AA;
					nxt.pfx = PFX_NONE;
					nxt.probe = 1'b0;
					nxt.pos = 2'd0;
				end
			endcase
		end else if (cur.phase != PH_WAIT_AA) begin
			timer_nxt = timer_inc;
			if (fire) begin
				if (cur.phase == PH_DROP) begin
					go_cmd = 1'b1;
					go_idx = CMD_FIRST;
				end else if (idle) begin
					if (cur.probe) begin
						go_lost = 1'b1;
					end else begin
						nxt.probe = 1'b1;
						timer_nxt = '0;
						res_v = 1'b1;
						res.kind = KIND_SEND;
						res.code = (cur.phase == PH_KEYBD) ? B_ECHO : B_READ_DATA;
						res.aux_prefix = cfg.aux;
					end
				end else begin
					go_fail = 1'b1;
				end
			end
		end

		if (go_cmd) begin
			nxt.phase = PH_CMD;
			nxt.cmd_idx = go_idx;
			timer_nxt = '0;
			res_v = 1'b1;
			res.kind = KIND_SEND;
			res.code = cmd_byte(go_idx);
			res.aux_prefix = cfg.aux;
		end
		if (go_fail || go_lost || go_kb_err) begin
			nxt.phase = PH_WAIT_AA;
			timer_nxt = '0;
			nxt.pfx = PFX_NONE;
			nxt.probe = 1'b0;
			nxt.pos = 2'd0;
			res_v = 1'b1;
			res.kind = KIND_STATUS;
			res.status = ST_LOST;
		end
		if (go_lost) begin
			nxt.setup_fails = 4'd0;
		end
		if (go_fail) begin
			nxt.setup_fails = fail_inc;
			res = '0;
			if (fail_inc < cfg.retry) begin
				res.kind = KIND_SEND;
				res.code = B_RESET;
				res.aux_prefix = cfg.aux;
			end else begin
				res.kind = KIND_STATUS;
				res.status = ST_GAVE_UP;
			end
		end
		if (go_ready) begin
			nxt.phase = ready_ph;
			timer_nxt = '0;
			nxt.pfx = PFX_NONE;
			nxt.probe = 1'b0;
			nxt.pos = 2'd0;
			res_v = 1'b1;
			res.kind = KIND_STATUS;
			res.status = ready_st;
		end
	end

endmodule

// ===== design/ps2_host_channel_engine.sv =====
// One PS/2 host channel: each beat on the item channel is either a byte received from the
// device (func 0) or one timer tick (func 1), and each beat yields at most one result beat
// (a byte to send, a key event, a mouse packet or a status). Every item passes from the
// input register through the combinational step logic into the result register, so one
// item is accepted per clock while the result register is free or being drained; a
// stalled result holds back the input register. Configuration registers are taken at any
// time with cfg_ready always high and should be written only while the channel is idle.
module ps2_host_channel_engine #(
	parameter int TIMER_BITS = ps2hce_pkg::TIMER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic func,
	input  logic [7:0] data_byte,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ps2hce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output logic res_valid,
	input  logic res_stall,
	output logic [1:0] kind,
	output logic [7:0] code,
	output logic key_release,
	output logic [7:0] pkt_byte0,
	output logic [7:0] pkt_byte1,
	output logic [7:0] pkt_byte2,
	output logic [7:0] pkt_byte3,
	output logic [2:0] pkt_len,
	output logic [2:0] status,
	output logic aux_prefix
);
	import ps2hce_pkg::*;
	`include "assert_macros.svh"

	cfg_t cfg_q;
	ctl_t ctl_q;
	ctl_t ctl_nxt;
	logic [TIMER_BITS-1:0] timer_q;
	logic [TIMER_BITS-1:0] timer_nxt;
	logic [2:0][7:0] store_q;
	logic store_we;
	logic [1:0] store_idx;
	logic v_s1;
	logic func_s1;
	logic [7:0] byte_s1;
	logic step_v;
	res_t step_res;
	logic res_v_q;
	res_t res_q;
	logic out_ready;
	logic adv;

	assign cfg_ready = 1'b1;
	assign out_ready = !res_v_q || !res_stall;
	assign adv = v_s1 && out_ready;
	assign item_stall = v_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_tmo <= WAIT_TMO_RST;
			cfg_q.idle_tmo <= IDLE_TMO_RST;
			cfg_q.retry <= RETRY_RST;
			cfg_q.aux <= 1'b0;
		end else if (cfg_valid) begin
			priority case (cfg_index)
				REG_WAIT_TMO: cfg_q.wait_tmo <= cfg_data[TMO_W-1:0];
				REG_IDLE_TMO: cfg_q.idle_tmo <= cfg_data[TMO_W-1:0];
				REG_RETRY: cfg_q.retry <= cfg_data[3:0];
				REG_AUX: cfg_q.aux <= cfg_data[0];
				default: cfg_q.aux <= cfg_q.aux;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!item_stall) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			func_s1 <= func;
			byte_s1 <= data_byte;
		end
	end

	ps2hce_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.cfg(cfg_q),
		.cur(ctl_q),
		.timer(timer_q),
		.store(store_q),
		.func(func_s1),
		.data_byte(byte_s1),
		.nxt(ctl_nxt),
		.timer_nxt(timer_nxt),
		.store_we(store_we),
		.store_idx(store_idx),
		.res_v(step_v),
		.res(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase <= PH_WAIT_AA;
			ctl_q.cmd_idx <= CMD_FIRST;
			ctl_q.setup_fails <= 4'd0;
			ctl_q.pfx <= PFX_NONE;
			ctl_q.probe <= 1'b0;
			ctl_q.pos <= 2'd0;
			ctl_q.wheel <= 1'b0;
			timer_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_nxt;
			timer_q <= timer_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && store_we) begin
			store_q[store_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (out_ready) begin
			res_v_q <= adv && step_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_v && out_ready) begin
			res_q <= step_res;
		end
	end

	assign res_valid = res_v_q;
	assign kind = res_q.kind;
	assign code = res_q.code;
	assign key_release = res_q.key_release;
	assign pkt_byte0 = res_q.pkt_byte0;
	assign pkt_byte1 = res_q.pkt_byte1;
	assign pkt_byte2 = res_q.pkt_byte2;
	assign pkt_byte3 = res_q.pkt_byte3;
	assign pkt_len = res_q.pkt_len;
	assign status = res_q.status;
	assign aux_prefix = res_q.aux_prefix;

	`CHK_IMPLY(a_stall_has_item, item_stall, v_s1, "item stalled with an empty input stage")
	`CHK_IMPLY(a_wait_timer_clear, ctl_q.phase == PH_WAIT_AA, timer_q == '0,
		"timer running while waiting for self test")
	`CHK_IMPLY(a_send_aux, res_v_q && res_q.kind == KIND_SEND, res_q.aux_prefix == cfg_q.aux,
		"send beat with wrong aux prefix")
	`CHK_IMPLY(a_len_only_pkt, res_v_q && res_q.kind != KIND_PKT, res_q.pkt_len == 3'd0,
		"packet length set on a non-packet beat")

endmodule

// ===== sim/ps2_host_channel_engine_tb.sv =====
module ps2_host_channel_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ps2hce_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 24;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEMS_PER_SETTING = 160;

	localparam logic [7:0] B_MOUSE_ID = 8'h00;
	localparam logic [7:0] B_KEY_OVERRUN = 8'h00;
	localparam logic [7:0] B_BAT_FAIL = 8'hFC;
	localparam logic [7:0] B_BAT_FAIL_ALT = 8'hFD;
	localparam logic [7:0] B_KEY_ERR = 8'hFF;

	localparam logic [7:0] setup_seq [17] = '{
		8'hF5, 8'hF2,
		8'hF3, 8'd200, 8'hF3, 8'd100, 8'hF3, 8'd80, 8'hF2,
		8'hF3, 8'd40, 8'hF4,
		8'hF0, 8'h02, 8'hF3, 8'h7F, 8'hF4
	};

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic func;
	logic [7:0] data_byte;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] code;
	logic key_release;
	logic [7:0] pkt_byte0;
	logic [7:0] pkt_byte1;
	logic [7:0] pkt_byte2;
	logic [7:0] pkt_byte3;
	logic [2:0] pkt_len;
	logic [2:0] status;
	logic aux_prefix;

	ps2_host_channel_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.data_byte(data_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.code(code),
		.key_release(key_release),
		.pkt_byte0(pkt_byte0),
		.pkt_byte1(pkt_byte1),
		.pkt_byte2(pkt_byte2),
		.pkt_byte3(pkt_byte3),
		.pkt_len(pkt_len),
		.status(status),
		.aux_prefix(aux_prefix)
	);

	// Channel state as the host should see it after every accepted beat.
	logic [TMO_W-1:0] wait_lim = WAIT_TMO_RST;
	logic [TMO_W-1:0] idle_lim = IDLE_TMO_RST;
	logic [3:0] retry_lim = RETRY_RST;
	logic aux_on = 1'b0;

	phase_t dev_phase = PH_WAIT_AA;
	logic [4:0] dev_cmd = CMD_FIRST;
	logic [3:0] fails = 4'd0;
	logic [TMO_W-1:0] ticks = '0;
	logic [1:0] pfx = PFX_NONE;
	logic probe = 1'b0;
	logic [7:0] pkt_store [3] = '{default: 8'h00};
	logic [1:0] pkt_pos = 2'd0;
	logic wheel = 1'b0;

	res_t expected_q [$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int kind_count [4] = '{default: 0};
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic res_t send_res(logic [7:0] b);
		res_t r = '0;
		r.kind = KIND_SEND;
		r.code = b;
		r.aux_prefix = aux_on;
		return r;
	endfunction

	function automatic res_t status_res(logic [2:0] s);
		res_t r = '0;
		r.kind = KIND_STATUS;
		r.status = s;
		return r;
	endfunction

	function automatic void go_wait_aa();
		dev_phase = PH_WAIT_AA;
		ticks = '0;
		pfx = PFX_NONE;
		probe = 1'b0;
		pkt_pos = 2'd0;
	endfunction

	function automatic res_t issue_cmd(logic [4:0] idx);
		dev_phase = PH_CMD;
		dev_cmd = idx;
		ticks = '0;
		return send_res(setup_seq[idx]);
	endfunction

	function automatic res_t setup_failed();
		go_wait_aa();
		if (fails != 4'hF)
			fails++;
		if (fails < retry_lim)
			return send_res(B_RESET);
		return status_res(ST_GAVE_UP);
	endfunction

	function automatic res_t go_ready(phase_t ph, logic [2:0] st);
		dev_phase = ph;
		ticks = '0;
		pfx = PFX_NONE;
		probe = 1'b0;
		pkt_pos = 2'd0;
		return status_res(st);
	endfunction

	task automatic predict_item(input logic is_tick, input logic [7:0] b, output bit hit,
			output res_t r);
		logic [TMO_W-1:0] lim;
		logic idle_ph;
		logic [2:0] plen;
		hit = 1'b1;
		r = '0;
		if (is_tick) begin
			idle_ph = (dev_phase == PH_KEYBD) || (dev_phase == PH_MOUSE);
			lim = idle_ph ? idle_lim : wait_lim;
			if (dev_phase == PH_WAIT_AA) begin
				hit = 1'b0;
			end else begin
				if (ticks != '1)
					ticks++;
				if (ticks < lim) begin
					hit = 1'b0;
				end else if (dev_phase == PH_DROP) begin
					r = issue_cmd(CMD_FIRST);
				end else if (idle_ph && probe) begin
					fails = 4'd0;
					go_wait_aa();
					r = status_res(ST_LOST);
				end else if (idle_ph) begin
					probe = 1'b1;
					ticks = '0;
					r = send_res(dev_phase == PH_KEYBD ? B_ECHO : B_READ_DATA);
				end else begin
					r = setup_failed();
				end
			end
			return;
		end
		ticks = '0;
		case (dev_phase)
			PH_CMD: begin
				if (b == B_RESEND)
					r = issue_cmd(dev_cmd);
				else if (b != B_ACK)
					r = setup_failed();
				else if (dev_cmd == CMD_ID) begin
					dev_phase = PH_ID1;
					hit = 1'b0;
				end else if (dev_cmd == CMD_M_ID) begin
					dev_phase = PH_M_ID2;
					hit = 1'b0;
				end else if (dev_cmd == CMD_M_LAST)
					r = go_ready(PH_MOUSE, wheel ? ST_WHEEL_READY : ST_MOUSE_READY);
				else if (dev_cmd == CMD_KB_LAST)
					r = go_ready(PH_KEYBD, ST_KB_READY);
				else
					r = issue_cmd(dev_cmd + 5'd1);
			end
			PH_WAIT_AA: begin
				if (b == B_SELFTEST) begin
					dev_phase = PH_DROP;
					r = status_res(ST_RESET_SEEN);
				end else begin
					hit = 1'b0;
				end
			end
			PH_DROP: r = issue_cmd(CMD_FIRST);
			PH_ID1: begin
				if (b == B_MOUSE_ID)
					r = issue_cmd(CMD_MOUSE);
				else if (b == B_KB_ID1) begin
					dev_phase = PH_KB_ID2;
					hit = 1'b0;
				end else
					r = setup_failed();
			end
			PH_KB_ID2: r = (b == B_KB_ID2) ? issue_cmd(CMD_KB) : setup_failed();
			PH_M_ID2: begin
				if (b == B_MOUSE_ID || b == B_WHEEL_ID) begin
					wheel = (b == B_WHEEL_ID);
					r = issue_cmd(CMD_M_TAIL);
				end else begin
					r = setup_failed();
				end
			end
			PH_KEYBD: begin
				probe = 1'b0;
				if (b == B_KEY_OVERRUN || b == B_SELFTEST || b == B_BAT_FAIL
						|| b == B_BAT_FAIL_ALT || b == B_RESEND || b == B_KEY_ERR) begin
					go_wait_aa();
					r = status_res(ST_LOST);
				end else if (b == B_ECHO || b == B_ACK) begin
					hit = 1'b0;
				end else if (pfx == PFX_NONE && (b == B_EXT || b == B_BREAK)) begin
					pfx = (b == B_EXT) ? PFX_E0 : PFX_F0;
					hit = 1'b0;
				end else if (pfx == PFX_E0 && b == B_BREAK) begin
					pfx = PFX_E0F0;
					hit = 1'b0;
				end else begin
					r.kind = KIND_KEY;
					r.code = ((pfx == PFX_E0 || pfx == PFX_E0F0) && !b[7]) ? b + 8'h80 : b;
					r.key_release = (pfx == PFX_F0 || pfx == PFX_E0F0);
					pfx = PFX_NONE;
				end
			end
			PH_MOUSE: begin
				plen = wheel ? 3'd4 : 3'd3;
				if (probe && b == B_ACK) begin
					probe = 1'b0;
					hit = 1'b0;
				end else if (pkt_pos == 2'd0 && !b[3]) begin
					hit = 1'b0;
				end else if (pkt_pos + 1 < plen) begin
					pkt_store[pkt_pos] = b;
					pkt_pos++;
					hit = 1'b0;
				end else begin
					r.kind = KIND_PKT;
					r.pkt_byte0 = pkt_store[0];
					r.pkt_byte1 = pkt_store[1];
					if (wheel) begin
						r.pkt_byte2 = pkt_store[2];
						r.pkt_byte3 = b;
					end else begin
						r.pkt_byte2 = b;
					end
					r.pkt_len = plen;
					pkt_pos = 2'd0;
				end
			end
			default: begin
				go_wait_aa();
				hit = 1'b0;
			end
		endcase
	endtask

	task automatic send_item(input logic is_tick, input logic [7:0] b);
		bit hit;
		res_t r;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		func <= is_tick;
		data_byte <= b;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		predict_item(is_tick, b, hit, r);
		if (hit)
			expected_q.push_back(r);
		items_sent++;
	endtask

	task automatic wait_channel_idle(input int extra);
		item_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
	endtask

	// Upper data bits carry noise; only the register width is kept.
	task automatic program_regs(input logic [TMO_W-1:0] wait_t, input logic [TMO_W-1:0] idle_t,
			input logic [3:0] retry, input logic aux);
		write_reg(REG_WAIT_TMO, {8'($urandom), wait_t});
		wait_lim = wait_t;
		write_reg(REG_IDLE_TMO, {8'($urandom), idle_t});
		idle_lim = idle_t;
		write_reg(REG_RETRY, {28'($urandom), retry});
		retry_lim = retry;
		write_reg(REG_AUX, {31'($urandom), aux});
		aux_on = aux;
		write_reg(8'($urandom_range(255, 4)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] next_device_byte();
		logic [7:0] b;
		int r;
		b = 8'($urandom);
		r = $urandom_range(99);
		if (r < 6)
			return b;
		case (dev_phase)
			PH_WAIT_AA: b = B_SELFTEST;
			PH_CMD: b = (r < 88) ? B_ACK : (r < 95) ? B_RESEND : b;
			PH_ID1: b = r[0] ? B_KB_ID1 : B_MOUSE_ID;
			PH_KB_ID2: b = B_KB_ID2;
			PH_M_ID2: b = r[0] ? B_WHEEL_ID : B_MOUSE_ID;
			PH_KEYBD: begin
				if (r < 30)
					b = r[0] ? B_EXT : B_BREAK;
				else if (r < 32)
					b = B_ACK;
				else if (r < 33)
					b = B_ECHO;
				else if (r < 80)
					b[7] = 1'b0;
			end
			PH_MOUSE: begin
				if (probe && r < 60)
					b = B_ACK;
				else if (pkt_pos == 2'd0 && r < 90)
					b[3] = 1'b1;
			end
			default: ;
		endcase
		return b;
	endfunction

	task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] seen);
		if (seen !== want) begin
			$display("t=%0t %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
			errors++;
		end
	endtask

	task automatic check_result();
		res_t want;
		res_t got;
		got = {kind, code, key_release, pkt_byte0, pkt_byte1, pkt_byte2, pkt_byte3, pkt_len,
			status, aux_prefix};
		if (expected_q.size() == 0) begin
			$display("t=%0t unexpected result beat: expected none, actual kind %0h code %0h",
				$time, kind, code);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		cmp_field("kind", 8'(want.kind), 8'(got.kind));
		cmp_field("code", want.code, got.code);
		cmp_field("key_release", 8'(want.key_release), 8'(got.key_release));
		cmp_field("pkt_byte0", want.pkt_byte0, got.pkt_byte0);
		cmp_field("pkt_byte1", want.pkt_byte1, got.pkt_byte1);
		cmp_field("pkt_byte2", want.pkt_byte2, got.pkt_byte2);
		cmp_field("pkt_byte3", want.pkt_byte3, got.pkt_byte3);
		cmp_field("pkt_len", 8'(want.pkt_len), 8'(got.pkt_len));
		cmp_field("status", 8'(want.status), 8'(got.status));
		cmp_field("aux_prefix", 8'(want.aux_prefix), 8'(got.aux_prefix));
		results_checked++;
		kind_count[want.kind]++;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0)
			check_result();
		res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((item_valid && item_stall === 1'b0) || (res_valid === 1'b1 && !res_stall)
				|| (cfg_valid && cfg_ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Watchdog expired after %0d cycles without a beat.", WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic test_defaults_after_reset();
		send_item(1'b0, 8'h55);
		send_item(1'b1, 8'($urandom));
		send_item(1'b0, B_SELFTEST);
		send_item(1'b0, 8'h41);
		send_item(1'b0, B_RESEND);
		send_item(1'b0, 8'h12);
	endtask

	task automatic test_keyboard_bringup();
		wait_channel_idle(SETTLE_CYCLES);
		program_regs(24'd2, 24'd3, 4'd2, 1'b1);
		send_item(1'b0, B_SELFTEST);
		send_item(1'b1, 8'($urandom));
		send_item(1'b1, 8'($urandom));
		send_item(1'b0, B_ACK);
		send_item(1'b0, B_ACK);
		send_item(1'b0, B_KB_ID1);
		send_item(1'b0, B_KB_ID2);
		repeat (5) send_item(1'b0, B_ACK);
	endtask

	task automatic test_key_decoding();
		send_item(1'b0, B_EXT);
		send_item(1'b0, B_BREAK);
		send_item(1'b0, 8'h75);
		send_item(1'b0, B_EXT);
		send_item(1'b0, 8'hF1);
		send_item(1'b0, B_BREAK);
		send_item(1'b0, 8'h1C);
		send_item(1'b0, B_BAT_FAIL);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_in);
		int burst;
		int n;
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		for (int s = 0; s < 4; s++) begin
			wait_channel_idle(SETTLE_CYCLES);
			case (s)
				0: program_regs(24'd1, 24'd1, 4'd1, 1'b1);
				1: program_regs(24'hFFFFFF, 24'hFFFFFF, 4'd15, 1'b0);
				default: program_regs(24'($urandom_range(6, 1)), 24'($urandom_range(10, 1)),
					4'($urandom_range(15, 1)), 1'($urandom_range(1, 0)));
			endcase
			n = 0;
			while (n < ITEMS_PER_SETTING) begin
				if ($urandom_range(99) < 7) begin
					burst = $urandom_range(12, 1);
					repeat (burst) send_item(1'b1, 8'($urandom));
					n += burst;
				end else begin
					send_item(1'b0, next_device_byte());
					n++;
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		func <= 1'b0;
		data_byte <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 21;
		stall_pct = 84;
		test_defaults_after_reset();
		test_keyboard_bringup();
		test_key_decoding();
		test_random_traffic(21, 84);
		test_random_traffic(84, 21);
		test_random_traffic(0, 0);
		wait_channel_idle(TAIL_CYCLES);
		if (expected_q.size() != 0) begin
			$display("t=%0t %0d result beats still outstanding", $time, expected_q.size());
			errors++;
		end
		$display("Drove %0d item beats and checked %0d result beats:", items_sent,
			results_checked);
		$display("  %0d sends, %0d key events, %0d mouse packets, %0d status beats.",
			kind_count[KIND_SEND], kind_count[KIND_KEY], kind_count[KIND_PKT],
			kind_count[KIND_STATUS]);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/ps2hce_pkg.sv
design/ps2hce_step.sv
design/ps2_host_channel_engine.sv
sim/ps2_host_channel_engine_tb.sv
